// File: hw/rtl/button_debounce_long_press_events_macros.svh
`ifndef BUTTON_DEBOUNCE_LONG_PRESS_EVENTS_MACROS_SVH
`define BUTTON_DEBOUNCE_LONG_PRESS_EVENTS_MACROS_SVH

// same-cycle implication, checked on clk while out of reset
`define BDLP_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define BDLP_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/bdlp_pkg.sv
package bdlp_pkg;

  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 4;
  localparam int FIRST_W  = 16;
  localparam int REPEAT_W = 14;
  localparam int RC_W     = 4;

  localparam logic [1:0] REG_LP_ENABLE   = 2'd0;
  localparam logic [1:0] REG_REPEAT_MODE = 2'd1;
  localparam logic [1:0] REG_FIRST_HOLD  = 2'd2;
  localparam logic [1:0] REG_REPEAT_TICKS = 2'd3;

  localparam logic [FIRST_W-1:0]  FIRST_HOLD_RESET   = 16'd100;
  localparam logic [REPEAT_W-1:0] REPEAT_TICKS_RESET = 14'd10;

  localparam logic [RC_W-1:0] FAST_EVENTS   = 4'd5;
  localparam logic [RC_W-1:0] MEDIUM_EVENTS = 4'd15;

  localparam logic [1:0] AMP_X4_SH = 2'd2;
  localparam logic [1:0] AMP_X2_SH = 2'd1;
  localparam logic [1:0] AMP_X1_SH = 2'd0;

  typedef struct packed {
    logic accept;
    logic down;
    logic was_up;
    logic enable;
    logic repeat_mode;
  } btn_ctl_t;

  typedef struct packed {
    logic single;
    logic rep;
    logic lng;
  } btn_evt_t;

endpackage

// File: hw/rtl/bdlp_if.sv
interface bdlp_in_if #(parameter int BUTTONS = 2);
  logic               valid;
  logic               ready;
  logic [BUTTONS-1:0] raw_buttons;

  modport source (output valid, output raw_buttons, input ready);
  modport sink (input valid, input raw_buttons, output ready);
endinterface

interface bdlp_out_if #(parameter int BUTTONS = 2);
  logic               valid;
  logic               ready;
  logic [BUTTONS-1:0] debounced_buttons;
  logic [BUTTONS-1:0] single_press;
  logic [BUTTONS-1:0] repeat_press;
  logic [BUTTONS-1:0] long_hold;

  modport source (output valid, output debounced_buttons, output single_press,
                  output repeat_press, output long_hold, input ready);
  modport sink (input valid, input debounced_buttons, input single_press,
                input repeat_press, input long_hold, output ready);
endinterface

// File: hw/rtl/bdlp_btn.sv
module bdlp_btn
  import bdlp_pkg::*;
#(
  parameter int COUNT_WIDTH = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  btn_ctl_t            ctl,
  input  logic [FIRST_W-1:0]  first_hold,
  input  logic [REPEAT_W-1:0] repeat_ticks,
  output btn_evt_t            evt
);

  localparam int EW = (COUNT_WIDTH > FIRST_W) ? COUNT_WIDTH : FIRST_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  logic [COUNT_WIDTH-1:0] cnt_r, cnt_nxt, lim_r, lim_nxt;
  logic                   done_r, done_nxt;
  logic [RC_W-1:0]        rc_r, rc_nxt;

  logic [COUNT_WIDTH-1:0] base_cnt, base_lim, inc, first_lim, rep_lim;
  logic                   base_done, hit;
  logic [RC_W-1:0]        base_rc;
  logic [1:0]             amp_sh;
  logic [FIRST_W-1:0]     rep_scaled;
  logic [EW-1:0]          first_ext, rep_ext;

  always_comb begin
    base_cnt  = ctl.was_up ? '0 : cnt_r;
    base_done = ctl.was_up ? 1'b0 : done_r;
    base_rc   = ctl.was_up ? '0 : rc_r;

    // limits saturate at the counter range
    first_ext = EW'(first_hold);
    first_lim = (first_ext > EW'(CNT_MAX)) ? CNT_MAX : first_ext[COUNT_WIDTH-1:0];
    base_lim  = ctl.was_up ? first_lim : lim_r;

    if (base_rc < FAST_EVENTS) begin
      amp_sh = AMP_X4_SH;
    end else if (base_rc < MEDIUM_EVENTS) begin
      amp_sh = AMP_X2_SH;
    end else begin
      amp_sh = AMP_X1_SH;
    end
    rep_scaled = FIRST_W'(repeat_ticks) << amp_sh;
    rep_ext    = EW'(rep_scaled);
    rep_lim    = (rep_ext > EW'(CNT_MAX)) ? CNT_MAX : rep_ext[COUNT_WIDTH-1:0];

    inc = (base_cnt == CNT_MAX) ? CNT_MAX : base_cnt + 1'b1;
    hit = (inc >= base_lim);

    cnt_nxt  = cnt_r;
    lim_nxt  = lim_r;
    done_nxt = done_r;
    rc_nxt   = rc_r;
    evt      = '0;

    if (ctl.down) begin
      if (!ctl.enable) begin
        evt.single = ctl.was_up;
      end else begin
        cnt_nxt  = inc;
        lim_nxt  = base_lim;
        done_nxt = base_done;
        rc_nxt   = base_rc;
        if (ctl.repeat_mode) begin
          if (hit) begin
            evt.rep = 1'b1;
            cnt_nxt = '0;
            lim_nxt = rep_lim;
            if (base_rc < MEDIUM_EVENTS) begin
              rc_nxt = base_rc + RC_W'(1);
            end
          end
        end else if (!base_done) begin
          if (hit) begin
            evt.lng  = 1'b1;
            done_nxt = 1'b1;
          end
        end else begin
          cnt_nxt = '0;
        end
      end
    end else begin
      evt.single = ctl.enable && !ctl.was_up && !done_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      lim_r  <= '0;
      done_r <= 1'b0;
      rc_r   <= '0;
    end else if (ctl.accept) begin
      cnt_r  <= cnt_nxt;
      lim_r  <= lim_nxt;
      done_r <= done_nxt;
      rc_r   <= rc_nxt;
    end
  end

endmodule

// File: hw/rtl/button_debounce_long_press_events.sv
// Debounced push buttons with single-press, one-shot long-hold and auto-repeat
// events. Each word on in_ch is one tick of raw active-low button levels; a bit
// of the debounced level changes only when two successive raw samples agree.
// Every accepted tick gives exactly one result word on out_ch in the next cycle,
// and a tick can be taken in every cycle: the per-button counter update and
// limit compare sit between the input handshake and the result register, and
// in_ch.ready drops only while that register holds a word out_ch has not
// taken. Registers are written over the APB-style port at byte address 4*i
// (long_press_enable_mask, repeat_mode_mask, first_hold_ticks, repeat_ticks),
// pready is always high, and writes are meant only while the block is idle.
`include "button_debounce_long_press_events_macros.svh"

module button_debounce_long_press_events
  import bdlp_pkg::*;
#(
  parameter int BUTTONS     = 2,
  parameter int COUNT_WIDTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  bdlp_in_if.sink           in_ch,
  bdlp_out_if.source        out_ch,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready
);

  logic [BUTTONS-1:0]  lp_en_r, rep_mode_r;
  logic [FIRST_W-1:0]  first_hold_r;
  logic [REPEAT_W-1:0] repeat_ticks_r;
  logic                cfg_wr;

  logic [BUTTONS-1:0] raw_prev_r, filt_prev_r;
  logic [BUTTONS-1:0] raw, filt;
  logic               accept;

  logic               out_valid_r;
  logic [BUTTONS-1:0] deb_r, single_r, rep_r, lng_r;
  logic [BUTTONS-1:0] single_v, rep_v, lng_v;

  // configuration port
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lp_en_r        <= '1;
      rep_mode_r     <= '0;
      first_hold_r   <= FIRST_HOLD_RESET;
      repeat_ticks_r <= REPEAT_TICKS_RESET;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        REG_LP_ENABLE:    lp_en_r        <= pwdata[BUTTONS-1:0];
        REG_REPEAT_MODE:  rep_mode_r     <= pwdata[BUTTONS-1:0];
        REG_FIRST_HOLD:   first_hold_r   <= pwdata[FIRST_W-1:0];
        REG_REPEAT_TICKS: repeat_ticks_r <= pwdata[REPEAT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_LP_ENABLE:    prdata = DATA_W'(lp_en_r);
      REG_REPEAT_MODE:  prdata = DATA_W'(rep_mode_r);
      REG_FIRST_HOLD:   prdata = DATA_W'(first_hold_r);
      REG_REPEAT_TICKS: prdata = DATA_W'(repeat_ticks_r);
      default:          prdata = '0;
    endcase
  end

  // two-sample hysteresis filter
  assign raw    = in_ch.raw_buttons;
  assign filt   = (~filt_prev_r & raw_prev_r & raw) | (filt_prev_r & (raw_prev_r | raw));
  assign accept = in_ch.valid && in_ch.ready;
  assign in_ch.ready = !out_valid_r || out_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      raw_prev_r  <= '0;
      filt_prev_r <= '1;
    end else if (accept) begin
      raw_prev_r  <= raw;
      filt_prev_r <= filt;
    end
  end

  for (genvar b = 0; b < BUTTONS; b++) begin : g_btn
    btn_ctl_t ctl;
    btn_evt_t evt;

    assign ctl.accept      = accept;
    assign ctl.down        = !filt[b];
    assign ctl.was_up      = filt_prev_r[b];
    assign ctl.enable      = lp_en_r[b];
    assign ctl.repeat_mode = rep_mode_r[b];

    bdlp_btn #(.COUNT_WIDTH(COUNT_WIDTH)) u_btn (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .first_hold   (first_hold_r),
      .repeat_ticks (repeat_ticks_r),
      .evt          (evt)
    );

    assign single_v[b] = evt.single;
    assign rep_v[b]    = evt.rep;
    assign lng_v[b]    = evt.lng;
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      deb_r    <= filt;
      single_r <= single_v;
      rep_r    <= rep_v;
      lng_r    <= lng_v;
    end
  end

  assign out_ch.valid             = out_valid_r;
  assign out_ch.debounced_buttons = deb_r;
  assign out_ch.single_press      = single_r;
  assign out_ch.repeat_press      = rep_r;
  assign out_ch.long_hold         = lng_r;

  `BDLP_ASSERT_IMP(a_evt_excl, out_ch.valid, ((out_ch.single_press & out_ch.repeat_press) | (out_ch.single_press & out_ch.long_hold) | (out_ch.repeat_press & out_ch.long_hold)) == '0, "two events on one button")
  `BDLP_ASSERT_IMP(a_hold_evt_down, out_ch.valid, ((out_ch.repeat_press | out_ch.long_hold) & out_ch.debounced_buttons) == '0, "hold event on released button")
  `BDLP_ASSERT_NXT(a_word_lands, in_ch.valid && in_ch.ready, out_ch.valid, "accepted word not presented")
  `BDLP_ASSERT_IMP(a_stall_full, !in_ch.ready, out_ch.valid, "input stalled with empty result register")

endmodule

// File: verif/bdlp_checker.sv
module bdlp_checker
  import bdlp_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  bdlp_in_if                tick_if,
  bdlp_out_if               result_if,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic              pready,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output int                fail_count,
  output int                pending
);

  typedef struct packed {
    logic [1:0] level;
    logic [1:0] single;
    logic [1:0] rep;
    logic [1:0] lng;
  } tick_word_t;

  logic [1:0]          lp_enable;
  logic [1:0]          auto_repeat;
  logic [FIRST_W-1:0]  first_hold;
  logic [REPEAT_W-1:0] repeat_base;

  logic [1:0]  raw_last;
  logic [1:0]  level_last;
  logic [15:0] held_ticks [2];
  logic [15:0] event_limit [2];
  logic        long_given [2];
  logic [3:0]  repeats_seen [2];

  tick_word_t expected_words [$];

  function automatic tick_word_t debounce_tick(input logic [1:0] raw);
    tick_word_t w;
    logic [1:0] lvl;
    logic [17:0] scaled;
    int b;
    lvl = (~level_last & raw_last & raw) | (level_last & (raw_last | raw));
    w = '0;
    w.level = lvl;
    for (b = 0; b < 2; b++) begin
      if (!lvl[b]) begin
        if (!lp_enable[b]) begin
          w.single[b] = level_last[b];
        end else begin
          if (level_last[b]) begin
            event_limit[b] = first_hold;
            held_ticks[b] = '0;
            long_given[b] = 1'b0;
            repeats_seen[b] = '0;
          end
          if (held_ticks[b] != 16'hffff) held_ticks[b] = held_ticks[b] + 16'd1;
          if (auto_repeat[b]) begin
            if (held_ticks[b] >= event_limit[b]) begin
              w.rep[b] = 1'b1;
              held_ticks[b] = '0;
              // multiplier steps down 4, 2, 1 as repeats accumulate
              if (repeats_seen[b] < FAST_EVENTS) begin
                repeats_seen[b] = repeats_seen[b] + 4'd1;
                scaled = 18'(repeat_base) * 18'd4;
              end else if (repeats_seen[b] < MEDIUM_EVENTS) begin
                repeats_seen[b] = repeats_seen[b] + 4'd1;
                scaled = 18'(repeat_base) * 18'd2;
              end else begin
                scaled = 18'(repeat_base);
              end
              event_limit[b] = (scaled > 18'h0ffff) ? 16'hffff : scaled[15:0];
            end
          end else if (!long_given[b]) begin
            if (held_ticks[b] >= event_limit[b]) begin
              w.lng[b] = 1'b1;
              long_given[b] = 1'b1;
            end
          end else begin
            held_ticks[b] = '0;
          end
        end
      end else if (lp_enable[b] && !level_last[b] && !long_given[b]) begin
        w.single[b] = 1'b1;
      end
    end
    raw_last = raw;
    level_last = lvl;
    return w;
  endfunction

  task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (got !== want) begin
      fail_count++;
      $display("%0t %s mismatch: expected %b actual %b", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    tick_word_t want;
    if (!rst_n) begin
      lp_enable = 2'b11;
      auto_repeat = 2'b00;
      first_hold = FIRST_HOLD_RESET;
      repeat_base = REPEAT_TICKS_RESET;
      raw_last = 2'b00;
      level_last = 2'b11;
      for (int b = 0; b < 2; b++) begin
        held_ticks[b] = '0;
        event_limit[b] = '0;
        long_given[b] = 1'b0;
        repeats_seen[b] = '0;
      end
      expected_words.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[ADDR_W-1:2])
          REG_LP_ENABLE:    lp_enable = pwdata[1:0];
          REG_REPEAT_MODE:  auto_repeat = pwdata[1:0];
          REG_FIRST_HOLD:   first_hold = pwdata[FIRST_W-1:0];
          REG_REPEAT_TICKS: repeat_base = pwdata[REPEAT_W-1:0];
          default: ;
        endcase
      end
      if (tick_if.valid && tick_if.ready)
        expected_words.push_back(debounce_tick(tick_if.raw_buttons));
      if (result_if.valid && result_if.ready) begin
        if (expected_words.size() == 0) begin
          fail_count++;
          $display("%0t unexpected result word: expected none actual %b %b %b %b", $time,
                   result_if.debounced_buttons, result_if.single_press,
                   result_if.repeat_press, result_if.long_hold);
        end else begin
          want = expected_words.pop_front();
          check_field("debounced_buttons", want.level, result_if.debounced_buttons);
          check_field("single_press", want.single, result_if.single_press);
          check_field("repeat_press", want.rep, result_if.repeat_press);
          check_field("long_hold", want.lng, result_if.long_hold);
        end
      end
    end
    pending = expected_words.size();
  end

endmodule

// File: verif/tb_top.sv
module tb_top;
  import bdlp_pkg::*;

  typedef enum {SINK_FREE, SINK_PERIODIC, SINK_RANDOM, SINK_BURSTY} sink_mode_e;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              result_ready = 1'b0;

  int fail_count;
  int pending;

  int         burst_left = 0;
  bit         no_gaps = 1'b0;
  bit         btn_down [2] = '{1'b0, 1'b0};
  int         btn_left [2] = '{0, 0};
  sink_mode_e sink_mode = SINK_FREE;
  int         sink_seg = 0;
  int         sink_run = 0;
  bit         sink_low = 1'b0;

  bdlp_in_if  tick_if ();
  bdlp_out_if result_if ();

  assign result_if.ready = result_ready;

  button_debounce_long_press_events u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (tick_if),
    .out_ch  (result_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  bdlp_checker u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .tick_if    (tick_if),
    .result_if  (result_if),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .pready     (pready),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .fail_count (fail_count),
    .pending    (pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // receiver stalls follow a randomly chosen mode that is redrawn whenever its segment runs out
  always @(posedge clk) begin
    if (sink_seg == 0) begin
      sink_mode = sink_mode_e'($urandom_range(0, 3));
      sink_seg = $urandom_range(20, 200);
    end
    sink_seg--;
    case (sink_mode)
      SINK_FREE:     result_ready <= 1'b1;
      SINK_PERIODIC: result_ready <= (sink_seg % 4) != 0;
      SINK_RANDOM:   result_ready <= 1'($urandom_range(0, 1));
      default: begin
        if (sink_run == 0) begin
          sink_low = !sink_low;
          sink_run = $urandom_range(1, 6);
        end
        sink_run--;
        result_ready <= !sink_low;
      end
    endcase
  end

  task automatic cfg_write(input logic [1:0] idx, input logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic cfg_all(input logic [1:0] lp, input logic [1:0] rm, input logic [15:0] fh,
                         input logic [13:0] rt);
    cfg_write(REG_LP_ENABLE, DATA_W'(lp));
    cfg_write(REG_REPEAT_MODE, DATA_W'(rm));
    cfg_write(REG_FIRST_HOLD, DATA_W'(fh));
    cfg_write(REG_REPEAT_TICKS, DATA_W'(rt));
  endtask

  task automatic send_tick(input logic [1:0] raw);
    int gap;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(0, 6);
      if (gap > 0) begin
        tick_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 40);
    end
    tick_if.valid <= 1'b1;
    tick_if.raw_buttons <= raw;
    do @(posedge clk); while (!tick_if.ready);
    if (burst_left > 0) burst_left--;
  endtask

  task automatic send_run(input logic [1:0] raw, input int count);
    repeat (count) send_tick(raw);
  endtask

  // wait with no word in flight until every result word has come back
  task automatic drain();
    tick_if.valid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // press and release runs per button, with single-tick bounce on top
  task automatic send_random_tick();
    logic [1:0] raw;
    int b;
    for (b = 0; b < 2; b++) begin
      if (btn_left[b] == 0) begin
        btn_down[b] = !btn_down[b];
        if (btn_down[b])
          btn_left[b] = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4) : $urandom_range(5, 90);
        else
          btn_left[b] = $urandom_range(2, 12);
      end
      btn_left[b]--;
      raw[b] = !btn_down[b];
      if ($urandom_range(0, 9) == 0) raw[b] = !raw[b];
    end
    send_tick(raw);
  endtask

  initial begin
    #100_000_000;
    $display("status: fail");
    $finish;
  end

  initial begin
    int ph;
    logic [15:0] fh;
    logic [13:0] rt;
    rst_n <= 1'b0;
    tick_if.valid <= 1'b0;
    tick_if.raw_buttons <= 2'b11;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // button 0 one-shot long hold, button 1 plain presses, with bounce
    cfg_all(2'b01, 2'b00, 16'd3, 14'd1);
    send_run(2'b00, 4);
    send_run(2'b11, 2);
    send_tick(2'b10);
    send_tick(2'b11);
    send_run(2'b10, 2);
    send_run(2'b11, 2);
    send_run(2'b01, 2);
    send_run(2'b11, 2);
    drain();

    // zero hold and repeat ticks, then release after repeats
    cfg_all(2'b11, 2'b11, 16'd0, 14'd0);
    send_run(2'b00, 5);
    send_run(2'b11, 2);
    send_run(2'b00, 3);
    drain();

    // switch to one-shot while both buttons stay down
    cfg_write(REG_REPEAT_MODE, DATA_W'(2'b00));
    cfg_write(REG_FIRST_HOLD, DATA_W'(16'd2));
    send_run(2'b00, 3);
    send_run(2'b11, 2);
    drain();

    // longest hold and repeat intervals
    cfg_all(2'b11, 2'b01, 16'hffff, 14'h3fff);
    no_gaps = 1'b1;
    send_run(2'b00, 40);
    send_run(2'b11, 2);
    no_gaps = 1'b0;
    drain();

    for (ph = 0; ph < 6; ph++) begin
      fh = ($urandom_range(0, 5) == 0) ? 16'($urandom_range(21, 65535))
                                       : 16'($urandom_range(0, 20));
      rt = ($urandom_range(0, 5) == 0) ? 14'($urandom_range(4, 16383))
                                       : 14'($urandom_range(0, 3));
      cfg_all(2'($urandom_range(0, 3)), 2'($urandom_range(0, 3)), fh, rt);
      repeat (270) send_random_tick();
      drain();
    end

    repeat (5) @(posedge clk);
    if (fail_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
